// ===== sv/lds_pkg.sv =====
package lds_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SECTOR_BITS_DEF = 48;

  localparam int TAG_W    = 8;
  localparam int SECTOR_W = 48;
  localparam int COUNT_W  = 16;
  localparam int PEND_W   = 5;

  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_REVERSE = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [TAG_W-1:0]    req_tag;
    logic [SECTOR_W-1:0] start_sector;
    logic [COUNT_W-1:0]  sector_count;
  } in_item_t;

  typedef struct packed {
    logic                dispatched;
    logic [TAG_W-1:0]    out_tag;
    logic [SECTOR_W-1:0] out_sector;
    logic [COUNT_W-1:0]  out_count;
    logic                add_rejected;
    logic [PEND_W-1:0]   pending;
    logic                sweep_dir;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_LAST,
    ST_FIN
  } state_t;

endpackage

// ===== sv/look_disk_request_scheduler_top.sv =====
// LOOK elevator disk scheduler over a table of QUEUE_DEPTH request slots held in one
// single-port synchronous memory (tag, start sector, sector count), with valid bits in
// flip-flops. One item is worked on at a time. An add walks the valid bits from slot 0 and
// writes the first free slot, or, when the table is full, rejects the add without walking the
// slots. A dispatch reads every slot once through the memory's read port, one slot per cycle,
// tracking the nearest start above and below the head. The next item is taken while a
// finished result still waits at the output register.
module look_disk_request_scheduler_top
  import lds_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W = TAG_W + SECTOR_BITS + COUNT_W;

  // slot memory: {tag, sector, count}
  logic [WORD_W-1:0] mem [QUEUE_DEPTH];
  logic [WORD_W-1:0] mem_q;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;

  state_t state_r, state_nxt;

  in_item_t               item_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [CNT_W-1:0]       pend_r;
  logic [SECTOR_BITS-1:0] head_r;
  logic                   rev_r;
  logic                   rej_r;

  logic                   up_found_r;
  logic [IDX_W-1:0]       up_idx_r;
  logic [TAG_W-1:0]       up_tag_r;
  logic [SECTOR_BITS-1:0] up_sec_r;
  logic [COUNT_W-1:0]     up_cnt_r;
  logic                   dn_found_r;
  logic [IDX_W-1:0]       dn_idx_r;
  logic [TAG_W-1:0]       dn_tag_r;
  logic [SECTOR_BITS-1:0] dn_sec_r;
  logic [COUNT_W-1:0]     dn_cnt_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic accept;
  logic fin_go;
  logic idx_last;
  logic pend_full;
  logic add_hit;

  logic [TAG_W-1:0]       q_tag;
  logic [SECTOR_BITS-1:0] q_sec;
  logic [COUNT_W-1:0]     q_cnt;
  logic                   q_live;
  logic                   q_up;
  logic                   q_dn;

  logic                   pick_any;
  logic                   take_up;
  logic                   new_rev;
  logic                   do_disp;
  logic [IDX_W-1:0]       sel_idx;
  logic [TAG_W-1:0]       sel_tag;
  logic [SECTOR_BITS-1:0] sel_sec;
  logic [COUNT_W-1:0]     sel_cnt;
  logic [CNT_W-1:0]       pend_after;
  out_item_t              res;

  assign idx_last  = (idx_r == IDX_W'(QUEUE_DEPTH - 1));
  assign pend_full = (pend_r == CNT_W'(QUEUE_DEPTH));

  // control outputs
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    accept   = in_valid && in_ready;
    fin_go   = (state_r == ST_FIN) && (!out_valid_r || out_ready);
    add_hit  = (state_r == ST_ADD) && !valid_r[idx_r];
    mem_we   = add_hit;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_DISPATCH) begin
            state_nxt = ST_SCAN;
          end else if (pend_full) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (!valid_r[idx_r] || idx_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (idx_last) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign mem_wdata = {item_r.req_tag, SECTOR_BITS'(item_r.start_sector), item_r.sector_count};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wdata;
    end
    mem_q <= mem[idx_r];
  end

  // compare data read back against the head
  always_comb begin
    q_tag  = mem_q[WORD_W-1 -: TAG_W];
    q_sec  = mem_q[COUNT_W +: SECTOR_BITS];
    q_cnt  = mem_q[COUNT_W-1:0];
    q_live = rd_vld_r && valid_r[rd_idx_r];
    q_up   = q_live && (q_sec >= head_r) && (!up_found_r || (q_sec < up_sec_r));
    q_dn   = q_live && (q_sec <= head_r) && (!dn_found_r || (q_sec > dn_sec_r));
  end

  // pick for the finishing dispatch
  always_comb begin
    pick_any = up_found_r || dn_found_r;
    take_up  = rev_r ? (!dn_found_r && up_found_r) : up_found_r;
    new_rev  = pick_any ? !take_up : rev_r;
    do_disp  = (item_r.mode == MODE_DISPATCH) && pick_any;
    sel_idx  = take_up ? up_idx_r : dn_idx_r;
    sel_tag  = take_up ? up_tag_r : dn_tag_r;
    sel_sec  = take_up ? up_sec_r : dn_sec_r;
    sel_cnt  = take_up ? up_cnt_r : dn_cnt_r;
    pend_after = do_disp ? (pend_r - CNT_W'(1)) : pend_r;

    res              = '0;
    res.dispatched   = do_disp;
    res.add_rejected = (item_r.mode == MODE_ADD) && rej_r;
    res.pending      = PEND_W'(pend_after);
    res.sweep_dir    = (item_r.mode == MODE_DISPATCH) ? new_rev : rev_r;
    if (do_disp) begin
      res.out_tag    = sel_tag;
      res.out_sector = SECTOR_W'(sel_sec);
      res.out_count  = sel_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      pend_r      <= '0;
      head_r      <= '0;
      rev_r       <= DIR_FORWARD;
      rej_r       <= 1'b0;
      up_found_r  <= 1'b0;
      dn_found_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_SCAN);

      if (accept) begin
        idx_r      <= '0;
        rej_r      <= (in_data.mode == MODE_ADD) && pend_full;
        up_found_r <= 1'b0;
        dn_found_r <= 1'b0;
      end else if (state_r == ST_ADD || state_r == ST_SCAN) begin
        idx_r <= idx_r + IDX_W'(1);
      end

      if (add_hit) begin
        valid_r[idx_r] <= 1'b1;
        pend_r         <= pend_r + CNT_W'(1);
      end

      if (q_up) begin
        up_found_r <= 1'b1;
      end
      if (q_dn) begin
        dn_found_r <= 1'b1;
      end

      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (do_disp) begin
          valid_r[sel_idx] <= 1'b0;
          pend_r           <= pend_after;
          head_r           <= sel_sec + SECTOR_BITS'(sel_cnt) - SECTOR_BITS'(1);
          rev_r            <= new_rev;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    rd_idx_r <= idx_r;
    if (q_up) begin
      up_idx_r <= rd_idx_r;
      up_tag_r <= q_tag;
      up_sec_r <= q_sec;
      up_cnt_r <= q_cnt;
    end
    if (q_dn) begin
      dn_idx_r <= rd_idx_r;
      dn_tag_r <= q_tag;
      dn_sec_r <= q_sec;
      dn_cnt_r <= q_cnt;
    end
    if (fin_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
